### rtl/dlp_pkg.sv
// dlp_pkg: shared constants for the DAG longest-path engine.
// No dependencies.
package dlp_pkg;
    localparam int DLP_MAX_NODES = 64;
    localparam int DLP_MAX_EDGES = 256;
    localparam int NODE_W        = 7;
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;
endpackage

### rtl/dlp_ram.sv
// dlp_ram: generic single-port-write, one-read RAM with registered read.
// No dependencies.
module dlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/dag_longest_path_engine_core.sv
// Top level of the DAG longest-path engine (Kahn order, longest city count).
// Depends on dlp_pkg and dlp_ram.
//
// channel  | handshake          | payload
// input    | start / busy       | req_type, from_node, to_node
// result   | out_valid strobe   | reachable, path_cities, city, last, edges_dropped
// config   | cfg_valid/cfg_ready| cfg_data (node_count), ready only while idle
//
// A load item is taken while idle and busy stays low. A run clears the node
// tables, counts in-degrees over the stored in-range edges, seeds the queue
// with the zero in-degree nodes, scans every stored edge for each dequeued
// node, finds the queue empty, reads the target, walks the path back a city
// at a time and emits a result per path city (one when unreachable). Every
// table is a RAM with registered read. Reset clears control state only; the
// node tables are cleared by the sweep at run start. Results cannot be stalled.
module dag_longest_path_engine_core #(
    parameter int MAX_NODES = dlp_pkg::DLP_MAX_NODES,
    parameter int MAX_EDGES = dlp_pkg::DLP_MAX_EDGES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      req_type,
    input  logic [dlp_pkg::NODE_W-1:0] from_node,
    input  logic [dlp_pkg::NODE_W-1:0] to_node,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dlp_pkg::NODE_W-1:0] cfg_data,
    output logic                      out_valid,
    output logic                      reachable,
    output logic [dlp_pkg::NODE_W-1:0] path_cities,
    output logic [dlp_pkg::NODE_W-1:0] city,
    output logic                      last,
    output logic                      edges_dropped
);
    import dlp_pkg::*;

    localparam int EA = $clog2(MAX_EDGES);
    localparam int EC = $clog2(MAX_EDGES + 1);
    localparam int NA = $clog2(MAX_NODES + 1);
    localparam int QA = $clog2(MAX_NODES);
    localparam int DW = EC;
    localparam logic [NODE_W-1:0] MAXN = NODE_W'(MAX_NODES);

    typedef enum logic [18:0] {
        S_IDLE   = 19'b0000000000000000001,
        S_CLR    = 19'b0000000000000000010,
        S_DEG    = 19'b0000000000000000100,
        S_DEGW   = 19'b0000000000000001000,
        S_DEGU   = 19'b0000000000000010000,
        S_SEED   = 19'b0000000000000100000,
        S_SEEDW  = 19'b0000000000001000000,
        S_DEQ    = 19'b0000000000010000000,
        S_DEQW   = 19'b0000000000100000000,
        S_DEQB   = 19'b0000000001000000000,
        S_SCAN   = 19'b0000000010000000000,
        S_SCANW  = 19'b0000000100000000000,
        S_SCANU  = 19'b0000001000000000000,
        S_CHECK  = 19'b0000010000000000000,
        S_CHECKW = 19'b0000100000000000000,
        S_WALK   = 19'b0001000000000000000,
        S_WALKW  = 19'b0010000000000000000,
        S_EMITR  = 19'b0100000000000000000,
        S_EMIT   = 19'b1000000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [NODE_W-1:0] node_count_reg;
    logic [EC-1:0]     edges_loaded_reg;
    logic              drop_reg;

    logic [EC-1:0]     eidx_reg;
    logic [NA-1:0]     nidx_reg;
    logic [NA-1:0]     head_reg, tail_reg;
    logic [NODE_W-1:0] u_reg, bu_reg, cur_reg, len_reg;
    logic [NA-1:0]     pidx_reg;

    logic [NODE_W-1:0] n_eff;
    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = NODE_W'(1);
        else if (node_count_reg > MAXN)
            n_eff = MAXN;
        else
            n_eff = node_count_reg;
    end

    // edge store: one RAM holding {source,target}
    logic              ram_we;
    logic [EA-1:0]     ram_raddr;
    logic [2*NODE_W-1:0] ram_rdata;
    logic [NODE_W-1:0] e_src, e_dst;
    dlp_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edges (
        .clk(clk), .we(ram_we), .waddr(edges_loaded_reg[EA-1:0]),
        .wdata({from_node, to_node}), .raddr(ram_raddr), .rdata(ram_rdata));
    assign e_src = ram_rdata[2*NODE_W-1:NODE_W];
    assign e_dst = ram_rdata[NODE_W-1:0];
    assign ram_raddr = eidx_reg[EA-1:0];

    // node tables, indexed by node number; one read and one write address shared by all three
    logic [NA-1:0]     nd_waddr, nd_raddr;
    logic              deg_we, best_we, pred_we;
    logic [DW-1:0]     deg_wdata, deg_rdata;
    logic [NODE_W-1:0] best_wdata, best_rdata, pred_wdata, pred_rdata;
    dlp_ram #(.WIDTH(DW), .DEPTH(MAX_NODES + 1)) u_indeg (
        .clk(clk), .we(deg_we), .waddr(nd_waddr), .wdata(deg_wdata),
        .raddr(nd_raddr), .rdata(deg_rdata));
    dlp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES + 1)) u_best (
        .clk(clk), .we(best_we), .waddr(nd_waddr), .wdata(best_wdata),
        .raddr(nd_raddr), .rdata(best_rdata));
    dlp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES + 1)) u_pred (
        .clk(clk), .we(pred_we), .waddr(nd_waddr), .wdata(pred_wdata),
        .raddr(nd_raddr), .rdata(pred_rdata));

    // ready queue and path buffer
    logic              q_we;
    logic [QA-1:0]     q_waddr, q_raddr;
    logic [NODE_W-1:0] q_wdata, q_rdata;
    dlp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata));

    logic              p_we;
    logic [QA-1:0]     p_waddr, p_raddr;
    logic [NODE_W-1:0] p_rdata;
    dlp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_path (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(cur_reg),
        .raddr(p_raddr), .rdata(p_rdata));
    assign q_waddr = tail_reg[QA-1:0];
    assign p_waddr = QA'(pidx_reg - NA'(1));

    logic accept, load_ok;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign load_ok   = from_node != '0 && from_node <= n_eff && to_node != '0
                       && to_node <= n_eff && edges_loaded_reg < EC'(MAX_EDGES);
    assign ram_we    = accept && req_type == REQ_LOAD && load_ok;

    logic v_in, e_in, e_hit, relax, unreach;
    assign v_in    = e_dst != '0 && e_dst <= n_eff;
    assign e_in    = e_src != '0 && e_src <= n_eff && v_in;
    assign e_hit   = e_src == u_reg && v_in;
    assign relax   = bu_reg != '0 && bu_reg + NODE_W'(1) > best_rdata;
    assign unreach = best_rdata == '0 || best_rdata > n_eff;

    logic [NODE_W-1:0] nlow;
    assign nlow = NODE_W'(nidx_reg);

    // table port control
    always_comb
    begin
        nd_raddr   = NA'(e_dst);
        nd_waddr   = NA'(e_dst);
        deg_we     = 1'b0;
        best_we    = 1'b0;
        pred_we    = 1'b0;
        deg_wdata  = deg_rdata + DW'(1);
        best_wdata = bu_reg + NODE_W'(1);
        pred_wdata = u_reg;
        q_we       = 1'b0;
        q_wdata    = e_dst;
        q_raddr    = head_reg[QA-1:0];
        p_we       = 1'b0;
        p_raddr    = pidx_reg[QA-1:0];
        unique case (state_reg)
            S_CLR:
            begin
                nd_waddr   = nidx_reg;
                deg_we     = 1'b1;
                best_we    = 1'b1;
                pred_we    = 1'b1;
                deg_wdata  = '0;
                best_wdata = (nidx_reg == NA'(1)) ? NODE_W'(1) : '0;
                pred_wdata = '0;
            end
            S_DEGU:
                deg_we = 1'b1;
            S_SEED:
                nd_raddr = nidx_reg;
            S_SEEDW:
            begin
                q_we    = (deg_rdata == '0);
                q_wdata = nlow;
            end
            S_DEQW:
                nd_raddr = NA'(q_rdata);
            S_SCANU:
            begin
                best_we   = relax;
                pred_we   = relax;
                deg_we    = (deg_rdata != '0);
                deg_wdata = deg_rdata - DW'(1);
                q_we      = (deg_rdata == DW'(1)) && (tail_reg < NA'(MAX_NODES));
            end
            S_CHECK:
                nd_raddr = NA'(n_eff);
            S_WALK:
            begin
                nd_raddr = NA'(cur_reg);
                p_we     = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept && req_type == REQ_RUN) state_next = S_CLR;
            S_CLR:    if (nidx_reg == NA'(MAX_NODES)) state_next = S_DEG;
            S_DEG:    state_next = (eidx_reg == edges_loaded_reg) ? S_SEED : S_DEGW;
            S_DEGW:   state_next = e_in ? S_DEGU : S_DEG;
            S_DEGU:   state_next = S_DEG;
            S_SEED:   state_next = S_SEEDW;
            S_SEEDW:  state_next = (nlow == n_eff) ? S_DEQ : S_SEED;
            S_DEQ:    state_next = (head_reg == tail_reg) ? S_CHECK : S_DEQW;
            S_DEQW:   state_next = S_DEQB;
            S_DEQB:   state_next = S_SCAN;
            S_SCAN:   state_next = (eidx_reg == edges_loaded_reg) ? S_DEQ : S_SCANW;
            S_SCANW:  state_next = e_hit ? S_SCANU : S_SCAN;
            S_SCANU:  state_next = S_SCAN;
            S_CHECK:  state_next = S_CHECKW;
            S_CHECKW: state_next = unreach ? S_EMIT : S_WALK;
            S_WALK:   state_next = S_WALKW;
            S_WALKW:  state_next = (pidx_reg == '0) ? S_EMITR : S_WALK;
            S_EMITR:  state_next = S_EMIT;
            S_EMIT:
                if (len_reg == '0 || pidx_reg + NA'(1) == NA'(len_reg))
                    state_next = S_IDLE;
                else
                    state_next = S_EMITR;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            node_count_reg   <= NODE_COUNT_RST;
            edges_loaded_reg <= '0;
            drop_reg         <= 1'b0;
            out_valid        <= 1'b0;
            eidx_reg <= '0; nidx_reg <= '0; head_reg <= '0; tail_reg <= '0;
            pidx_reg <= '0; len_reg <= '0;
            u_reg <= '0; bu_reg <= '0; cur_reg <= '0;
            reachable <= 1'b0; path_cities <= '0; city <= '0; last <= 1'b0;
            edges_dropped <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
                node_count_reg <= cfg_data;
            unique case (state_reg)
                S_IDLE:
                begin
                    eidx_reg <= '0;
                    nidx_reg <= '0;
                    head_reg <= '0;
                    tail_reg <= '0;
                    if (accept && req_type == REQ_LOAD)
                    begin
                        if (load_ok)
                            edges_loaded_reg <= edges_loaded_reg + EC'(1);
                        else
                            drop_reg <= 1'b1;
                    end
                end
                S_CLR:
                    nidx_reg <= (nidx_reg == NA'(MAX_NODES)) ? NA'(1)
                                                             : nidx_reg + NA'(1);
                S_DEG: ;
                S_DEGW:
                    if (!e_in)
                        eidx_reg <= eidx_reg + EC'(1);
                S_DEGU:
                    eidx_reg <= eidx_reg + EC'(1);
                S_SEED: ;
                S_SEEDW:
                begin
                    if (deg_rdata == '0)
                        tail_reg <= tail_reg + NA'(1);
                    nidx_reg <= nidx_reg + NA'(1);
                end
                S_DEQ:
                begin
                    eidx_reg <= '0;
                    if (head_reg != tail_reg)
                        head_reg <= head_reg + NA'(1);
                end
                S_DEQW:
                    u_reg <= q_rdata;
                S_DEQB:
                    bu_reg <= best_rdata;
                S_SCAN: ;
                S_SCANW:
                    if (!e_hit)
                        eidx_reg <= eidx_reg + EC'(1);
                S_SCANU:
                begin
                    eidx_reg <= eidx_reg + EC'(1);
                    if (q_we)
                        tail_reg <= tail_reg + NA'(1);
                end
                S_CHECK: ;
                S_CHECKW:
                begin
                    cur_reg  <= n_eff;
                    len_reg  <= unreach ? '0 : best_rdata;
                    pidx_reg <= unreach ? '0 : NA'(best_rdata);
                end
                S_WALK:
                    pidx_reg <= pidx_reg - NA'(1);
                S_WALKW:
                    cur_reg <= pred_rdata;
                S_EMITR: ;
                S_EMIT:
                begin
                    out_valid     <= 1'b1;
                    edges_dropped <= drop_reg;
                    if (len_reg == '0)
                    begin
                        reachable <= 1'b0; path_cities <= '0; city <= '0; last <= 1'b1;
                    end
                    else
                    begin
                        reachable   <= 1'b1;
                        path_cities <= len_reg;
                        city        <= p_rdata;
                        last        <= (pidx_reg + NA'(1) == NA'(len_reg));
                    end
                    pidx_reg <= pidx_reg + NA'(1);
                    if (state_next == S_IDLE)
                    begin
                        edges_loaded_reg <= '0;
                        drop_reg         <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/dlp_checker.sv
// dlp_checker: port-level assertions for dag_longest_path_engine_core.
// Depends on dlp_pkg; bound to the top level below.
module dlp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic out_valid,
    input logic reachable,
    input logic last,
    input logic [dlp_pkg::NODE_W-1:0] path_cities,
    input logic [dlp_pkg::NODE_W-1:0] city
);
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> busy) else $error("result outside run");
    a_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reachable |-> last && path_cities == '0 && city == '0)
        else $error("bad unreachable result");
    a_reach: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reachable |-> path_cities != '0 && city != '0)
        else $error("bad path result");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |=> !out_valid) else $error("result after last");
endmodule

bind dag_longest_path_engine_core dlp_checker u_dlp_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
    .reachable(reachable), .last(last), .path_cities(path_cities), .city(city));
